// ===== src/pwm_tpc_pkg.sv =====
// ----------------------------------------------------------------------------
// PWM timing prescaler calculator - shared definitions
// Field widths, reset values, result codes and default parameter values.
// ----------------------------------------------------------------------------
package pwm_tpc_pkg;

   localparam int unsigned DEF_CHANNELS    = 8;
   localparam int unsigned DEF_MAX_COUNT   = 8191;
   localparam int unsigned DEF_MAX_DIVIDER = 7;

   localparam int unsigned CH_W     = 3;
   localparam int unsigned TIME_W   = 31;
   localparam int unsigned RATE_W   = 30;
   localparam int unsigned STATUS_W = 2;
   localparam int unsigned MASK_W   = 8;

   // tick length in ps fits 40 bits, time in ps fits 41 bits
   localparam int unsigned TICK_W  = 40;
   localparam int unsigned PNUM_W  = 41;
   localparam int unsigned SCALE_W = 10;

   localparam logic [RATE_W-1:0]  RATE_RESET = 30'd26_000_000;
   localparam logic [TICK_W-1:0]  PS_PER_S   = 40'd1_000_000_000_000;
   localparam logic [SCALE_W-1:0] PS_PER_NS  = 10'd1000;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK       = 2'd0,
      STATUS_POLARITY = 2'd1,
      STATUS_PERIOD   = 2'd2
   } status_type;

endpackage

// ===== src/pwm_tpc_div.sv =====
// ----------------------------------------------------------------------------
// PWM timing prescaler calculator - shared divider
// Restoring unsigned divider, one quotient bit per cycle. Loads on start,
// pulses done for one cycle when the quotient is ready.
// ----------------------------------------------------------------------------
module pwm_tpc_div #(
   parameter int unsigned WIDTH = 49
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [WIDTH-1:0] dividend,
   input  logic [WIDTH-1:0] divisor,
   output logic             done,
   output logic [WIDTH-1:0] quotient
);

   localparam int unsigned CNT_W = $clog2(WIDTH);

   logic             run_ff;
   logic             done_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic [WIDTH-1:0] rem_ff;
   logic [WIDTH-1:0] quo_ff;
   logic [WIDTH-1:0] den_ff;

   logic [WIDTH:0]   trial;
   logic [WIDTH:0]   diff;
   logic             borrow;

   // shift the next dividend bit into the partial remainder and try a subtract
   assign trial  = {rem_ff, quo_ff[WIDTH-1]};
   assign diff   = trial - {1'b0, den_ff};
   assign borrow = diff[WIDTH];

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            run_ff <= 1'b1;
            cnt_ff <= '0;
            quo_ff <= dividend;
            rem_ff <= '0;
            den_ff <= divisor;
         end else if (run_ff) begin
            rem_ff <= borrow ? trial[WIDTH-1:0] : diff[WIDTH-1:0];
            quo_ff <= {quo_ff[WIDTH-2:0], ~borrow};
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(WIDTH - 1)) begin
               run_ff  <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

// ===== src/pwm_timing_prescaler_calc_unit.sv =====
// Timing: refused, stop and out-of-range requests give their result in the cycle after start.
// A run request takes dv + 3 divisions on the shared divider, dv being the divider found:
// the tick length, one period division per divider tried, then the duty; a period too
// long stops after MAX_DIVIDER + 2 divisions.
// Throughput: one request at a time, set by the shared divider; results never stall.
// Reset: clock rate returns to 26 MHz, all channel run bits clear, block idle.
// ----------------------------------------------------------------------------
// PWM timing prescaler calculator
// Works out tick length, divider exponent, period and duty counts for one
// channel request and keeps the per-channel run mask.
// ----------------------------------------------------------------------------
module pwm_timing_prescaler_calc_unit
   import pwm_tpc_pkg::*;
#(
   parameter int unsigned CHANNELS    = DEF_CHANNELS,
   parameter int unsigned MAX_COUNT   = DEF_MAX_COUNT,
   parameter int unsigned MAX_DIVIDER = DEF_MAX_DIVIDER,
   localparam int unsigned CNT_W      = $clog2(MAX_COUNT + 1),
   localparam int unsigned DIV_W      = (MAX_DIVIDER < 1) ? 1 : $clog2(MAX_DIVIDER + 1)
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_wr_en,
   input  logic [RATE_W-1:0]   csr_wr_data,
   input  logic                start,
   output logic                busy,
   input  logic [CH_W-1:0]     req_channel,
   input  logic                req_enable_request,
   input  logic                req_inverted_polarity,
   input  logic [TIME_W-1:0]   req_period_time,
   input  logic [TIME_W-1:0]   req_duty_time,
   output logic                rsp_valid,
   output logic [STATUS_W-1:0] rsp_status,
   output logic                rsp_timing_written,
   output logic [DIV_W-1:0]    rsp_clock_divider,
   output logic [CNT_W-1:0]    rsp_period_count,
   output logic [CNT_W-1:0]    rsp_duty_count,
   output logic [MASK_W-1:0]   rsp_enable_mask
);

   localparam int unsigned NW = 42 + MAX_DIVIDER;

   typedef enum logic [2:0] {
      S_IDLE,
      S_TICK_GO,
      S_TICK,
      S_PER_GO,
      S_PER,
      S_DUTY_GO,
      S_DUTY
   } state_type;

   state_type            state_ff, state_in;
   logic [RATE_W-1:0]    rate_ff;
   logic [CHANNELS-1:0]  run_ff, run_in;
   logic [CHANNELS-1:0]  ch_sel_ff, ch_sel_in;
   logic [PNUM_W-1:0]    pnum_ff, pnum_in;
   logic [PNUM_W-1:0]    dnum_ff, dnum_in;
   logic [NW-1:0]        den_ff, den_in;
   logic [DIV_W-1:0]     dv_ff, dv_in;
   logic [CNT_W-1:0]     pcnt_ff, pcnt_in;

   logic                 rsp_valid_ff, rsp_valid_in;
   status_type           rsp_status_ff, rsp_status_in;
   logic                 rsp_written_ff, rsp_written_in;
   logic [DIV_W-1:0]     rsp_div_ff, rsp_div_in;
   logic [CNT_W-1:0]     rsp_pcnt_ff, rsp_pcnt_in;
   logic [CNT_W-1:0]     rsp_dcnt_ff, rsp_dcnt_in;
   logic [MASK_W-1:0]    rsp_mask_ff, rsp_mask_in;

   logic [CHANNELS-1:0]  req_onehot;
   logic [RATE_W-1:0]    rate_eff;
   logic                 div_start;
   logic [NW-1:0]        div_dividend;
   logic [NW-1:0]        div_divisor;
   logic                 div_done;
   logic [NW-1:0]        div_quotient;

   always_comb begin
      for (int i = 0; i < CHANNELS; i++) begin
         req_onehot[i] = (req_channel == CH_W'(i));
      end
   end

   // a zero rate counts as 1 Hz
   assign rate_eff = (rate_ff == '0) ? RATE_W'(1) : rate_ff;

   pwm_tpc_div #(
      .WIDTH (NW)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .done     (div_done),
      .quotient (div_quotient)
   );

   always_comb begin
      state_in       = state_ff;
      run_in         = run_ff;
      ch_sel_in      = ch_sel_ff;
      pnum_in        = pnum_ff;
      dnum_in        = dnum_ff;
      den_in         = den_ff;
      dv_in          = dv_ff;
      pcnt_in        = pcnt_ff;
      rsp_valid_in   = 1'b0;
      rsp_status_in  = rsp_status_ff;
      rsp_written_in = rsp_written_ff;
      rsp_div_in     = rsp_div_ff;
      rsp_pcnt_in    = rsp_pcnt_ff;
      rsp_dcnt_in    = rsp_dcnt_ff;
      rsp_mask_in    = rsp_mask_ff;
      div_start      = 1'b0;
      div_dividend   = '0;
      div_divisor    = '0;

      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               ch_sel_in      = req_onehot;
               pnum_in        = PNUM_W'(req_period_time) * PNUM_W'(PS_PER_NS);
               dnum_in        = PNUM_W'(req_duty_time) * PNUM_W'(PS_PER_NS);
               dv_in          = '0;
               rsp_status_in  = STATUS_OK;
               rsp_written_in = 1'b0;
               rsp_div_in     = '0;
               rsp_pcnt_in    = '0;
               rsp_dcnt_in    = '0;
               priority if (req_inverted_polarity) begin
                  rsp_status_in = STATUS_POLARITY;
                  rsp_valid_in  = 1'b1;
               end else if (!(|req_onehot)) begin
                  rsp_valid_in = 1'b1;
               end else if (!req_enable_request) begin
                  run_in       = run_ff & ~req_onehot;
                  rsp_valid_in = 1'b1;
               end else begin
                  state_in = S_TICK_GO;
               end
               rsp_mask_in = MASK_W'(run_in);
            end
         end
         S_TICK_GO: begin
            div_start    = 1'b1;
            div_dividend = NW'(PS_PER_S);
            div_divisor  = NW'(rate_eff);
            state_in     = S_TICK;
         end
         S_TICK: begin
            if (div_done) begin
               den_in   = div_quotient;
               state_in = S_PER_GO;
            end
         end
         S_PER_GO: begin
            // round to closest: add half the divisor before dividing
            div_start    = 1'b1;
            div_dividend = NW'(pnum_ff) + (den_ff >> 1);
            div_divisor  = den_ff;
            state_in     = S_PER;
         end
         S_PER: begin
            if (div_done) begin
               if (div_quotient > NW'(MAX_COUNT)) begin
                  if (dv_ff == DIV_W'(MAX_DIVIDER)) begin
                     // drop the request, leave run bits alone
                     rsp_status_in = STATUS_PERIOD;
                     rsp_valid_in  = 1'b1;
                     state_in      = S_IDLE;
                  end else begin
                     dv_in    = dv_ff + 1'b1;
                     den_in   = den_ff << 1;
                     state_in = S_PER_GO;
                  end
               end else begin
                  pcnt_in  = div_quotient[CNT_W-1:0];
                  state_in = S_DUTY_GO;
               end
            end
         end
         S_DUTY_GO: begin
            div_start    = 1'b1;
            div_dividend = NW'(dnum_ff) + (den_ff >> 1);
            div_divisor  = den_ff;
            state_in     = S_DUTY;
         end
         S_DUTY: begin
            if (div_done) begin
               run_in         = run_ff | ch_sel_ff;
               rsp_written_in = 1'b1;
               rsp_div_in     = dv_ff;
               rsp_pcnt_in    = pcnt_ff;
               rsp_dcnt_in    = (div_quotient > NW'(MAX_COUNT)) ?
                                CNT_W'(MAX_COUNT) : div_quotient[CNT_W-1:0];
               rsp_mask_in    = MASK_W'(run_in);
               rsp_valid_in   = 1'b1;
               state_in       = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rate_ff      <= RATE_RESET;
         run_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff       <= state_in;
         if (csr_wr_en) begin
            rate_ff <= csr_wr_data;
         end
         run_ff         <= run_in;
         ch_sel_ff      <= ch_sel_in;
         pnum_ff        <= pnum_in;
         dnum_ff        <= dnum_in;
         den_ff         <= den_in;
         dv_ff          <= dv_in;
         pcnt_ff        <= pcnt_in;
         rsp_valid_ff   <= rsp_valid_in;
         rsp_status_ff  <= rsp_status_in;
         rsp_written_ff <= rsp_written_in;
         rsp_div_ff     <= rsp_div_in;
         rsp_pcnt_ff    <= rsp_pcnt_in;
         rsp_dcnt_ff    <= rsp_dcnt_in;
         rsp_mask_ff    <= rsp_mask_in;
      end
   end

   assign busy               = (state_ff != S_IDLE);
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = rsp_status_ff;
   assign rsp_timing_written = rsp_written_ff;
   assign rsp_clock_divider  = rsp_div_ff;
   assign rsp_period_count   = rsp_pcnt_ff;
   assign rsp_duty_count     = rsp_dcnt_ff;
   assign rsp_enable_mask    = rsp_mask_ff;

   a_no_beat_while_busy: assert property (@(posedge clock) disable iff (reset)
      busy |-> !rsp_valid)
      else $error("result beat while a computation is in flight");

   a_busy_ends_in_beat: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && $fell(busy)) |-> rsp_valid)
      else $error("computation finished without a result beat");

   a_unwritten_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_timing_written) |->
         (rsp_clock_divider == '0 && rsp_period_count == '0 && rsp_duty_count == '0))
      else $error("timing fields set on a beat that wrote no timing");

   a_written_ok: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_timing_written) |->
         (rsp_status == STATUS_OK && rsp_period_count <= CNT_W'(MAX_COUNT)
          && rsp_duty_count <= CNT_W'(MAX_COUNT)))
      else $error("written timing with bad status or count out of range");

endmodule
